// File: sv/bmsi_pkg.sv
// Shared types, constants and bank mask helpers for the bank mapper with scanline IRQ.
// Used by every module of the block; depends on nothing.
package bmsi_pkg;

	localparam int PRG_ADDR_BITS = 19;
	localparam int CHR_ADDR_BITS = 18;
	localparam int MEM_ADDR_W = 19;
	localparam int PRG_BANK_W = PRG_ADDR_BITS - 13;
	localparam int CHR_BANK_W = CHR_ADDR_BITS - 10;
	localparam logic [2:0] SIZE_LOG2_MAX = 3'd5;

	localparam logic [2:0] REQ_CPU_WR = 3'd0;
	localparam logic [2:0] REQ_CPU_RD = 3'd1;
	localparam logic [2:0] REQ_PPU_RD = 3'd2;
	localparam logic [2:0] REQ_PPU_WR = 3'd3;
	localparam logic [2:0] REQ_TICK = 3'd4;

	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_PRG_ROM = 2'd1;
	localparam logic [1:0] TGT_PRG_RAM = 2'd2;
	localparam logic [1:0] TGT_CHR = 2'd3;

	localparam logic [1:0] CFG_PRG_SIZE = 2'd0;
	localparam logic [1:0] CFG_CHR_SIZE = 2'd1;
	localparam logic [1:0] CFG_CHR_RAM = 2'd2;

	localparam logic [1:0] REG_BANK = 2'd0;
	localparam logic [1:0] REG_MIRROR = 2'd1;
	localparam logic [1:0] REG_IRQ_CNT = 2'd2;
	localparam logic [1:0] REG_IRQ_EN = 2'd3;

	typedef logic [7:0][7:0] bank_regs_t;

	typedef struct packed {
		logic [2:0] prg_size_log2;
		logic [2:0] chr_size_log2;
		logic       chr_is_ram;
		logic       prg_swap;
		logic       chr_invert;
	} xlate_ctrl_t;

	function automatic logic [PRG_BANK_W-1:0] prg_window_mask(input logic [2:0] lg);
		int n;
		logic [PRG_BANK_W-1:0] m;
		n = ((lg > SIZE_LOG2_MAX) ? 5 : int'(lg)) + 1;
		if (n > PRG_BANK_W) begin
			n = PRG_BANK_W;
		end
		for (int i = 0; i < PRG_BANK_W; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

	function automatic logic [CHR_BANK_W-1:0] chr_window_mask(input logic [2:0] lg);
		int n;
		logic [CHR_BANK_W-1:0] m;
		n = ((lg > SIZE_LOG2_MAX) ? 5 : int'(lg)) + 3;
		if (n > CHR_BANK_W) begin
			n = CHR_BANK_W;
		end
		for (int i = 0; i < CHR_BANK_W; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

endpackage

// File: sv/bmsi_xlate.sv
// Address translation for one bus access: PRG windows, PRG RAM and CHR windows.
// Purely combinational; depends on bmsi_pkg.
module bmsi_xlate import bmsi_pkg::*; (
	input  logic [2:0]            req_type,
	input  logic [15:0]           addr,
	input  xlate_ctrl_t           ctrl,
	input  bank_regs_t            bank_regs,
	output logic [1:0]            target,
	output logic [MEM_ADDR_W-1:0] mem_addr,
	output logic                  mem_write
);

	logic [PRG_BANK_W-1:0]    prg_win_mask;
	logic [PRG_BANK_W-1:0]    prg_win;
	logic [1:0]               prg_slot;
	logic [PRG_ADDR_BITS-1:0] prg_addr;
	logic [CHR_BANK_W-1:0]    chr_win_mask;
	logic [2:0]               chr_slot;
	logic [7:0]               chr_raw;
	logic [CHR_ADDR_BITS-1:0] chr_addr;
	logic                     cpu_rom;
	logic                     cpu_ram;
	logic                     ppu_pat;

	always_comb begin
		prg_win_mask = prg_window_mask(ctrl.prg_size_log2);
		prg_slot = addr[14:13];
		priority if (prg_slot == 2'd1) begin
			prg_win = bank_regs[7][PRG_BANK_W-1:0];
		end else if (prg_slot == 2'd3) begin
			prg_win = prg_win_mask;
		end else if ((prg_slot == 2'd0) != ctrl.prg_swap) begin
			prg_win = bank_regs[6][PRG_BANK_W-1:0];
		end else begin
			prg_win = (prg_win_mask - PRG_BANK_W'(1)) & prg_win_mask;
		end
		prg_addr = {prg_win & prg_win_mask, addr[12:0]};
	end

	always_comb begin
		chr_win_mask = chr_window_mask(ctrl.chr_size_log2);
		chr_slot = addr[12:10] ^ {ctrl.chr_invert, 2'b00};
		if (!chr_slot[2]) begin
			chr_raw = bank_regs[{2'b00, chr_slot[1]}];
			chr_raw = {chr_raw[7:1], chr_slot[0]};
		end else begin
			chr_raw = bank_regs[chr_slot - 3'd2];
		end
		chr_addr = {chr_raw[CHR_BANK_W-1:0] & chr_win_mask, addr[9:0]};
	end

	assign cpu_rom = addr[15];
	assign cpu_ram = (addr[15:13] == 3'b011);
	assign ppu_pat = (addr[15:13] == 3'b000);

	always_comb begin
		target = TGT_NONE;
		mem_addr = '0;
		mem_write = 1'b0;
		unique case (req_type)
			REQ_CPU_RD: begin
				if (cpu_rom) begin
					target = TGT_PRG_ROM;
					mem_addr = MEM_ADDR_W'(prg_addr);
				end else if (cpu_ram) begin
					target = TGT_PRG_RAM;
					mem_addr = MEM_ADDR_W'(addr[12:0]);
				end
			end
			REQ_CPU_WR: begin
				if (!cpu_rom && cpu_ram) begin
					target = TGT_PRG_RAM;
					mem_addr = MEM_ADDR_W'(addr[12:0]);
					mem_write = 1'b1;
				end
			end
			REQ_PPU_RD: begin
				if (ppu_pat) begin
					target = TGT_CHR;
					mem_addr = MEM_ADDR_W'(chr_addr);
				end
			end
			REQ_PPU_WR: begin
				if (ppu_pat && ctrl.chr_is_ram) begin
					target = TGT_CHR;
					mem_addr = MEM_ADDR_W'(chr_addr);
					mem_write = 1'b1;
				end
			end
			default: begin
				target = TGT_NONE;
			end
		endcase
	end

endmodule

// File: sv/bank_mapper_scanline_irq_core.sv
// Top level of the bank mapper with scanline IRQ: input stage, mapper registers,
// IRQ counter and result register. Depends on bmsi_pkg and bmsi_xlate.
//
//   port group | handshake           | carries
//   input      | in_valid, in_ready  | req_type, addr, data
//   result     | out_valid, out_ready| target, mem_addr, mem_write, irq_line, mirror_horizontal
//   config     | cfg_we              | cfg_idx, cfg_data
//
// Each word is registered first in the input stage and then in the result register.
// Throughput is one word per cycle while out_ready is high.
// The mapper and IRQ state update as a word moves from the input stage to the result register.
// A stalled result holds the input stage; in_ready drops only when both are full.
// Reset clears all mapper state and sets chr_is_ram.
module bank_mapper_scanline_irq_core import bmsi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [2:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            req_type,
	input  logic [15:0]           addr,
	input  logic [7:0]            data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            target,
	output logic [MEM_ADDR_W-1:0] mem_addr,
	output logic                  mem_write,
	output logic                  irq_line,
	output logic                  mirror_horizontal
);

	logic [2:0]  prg_size_q;
	logic [2:0]  chr_size_q;
	logic        chr_ram_q;
	logic [2:0]  bank_select_q;
	logic        prg_swap_q;
	logic        chr_invert_q;
	bank_regs_t  bank_regs_q;
	logic        mirror_q;
	logic [7:0]  irq_period_q;
	logic [7:0]  irq_count_q;
	logic        irq_rearm_q;
	logic        irq_en_q;
	logic        irq_pend_q;

	logic        valid_s1;
	logic [2:0]  req_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic        out_valid_q;
	logic [1:0]  target_q;
	logic [MEM_ADDR_W-1:0] mem_addr_q;
	logic        mem_write_q;
	logic        irq_q;
	logic        mirror_out_q;

	logic        advance;
	xlate_ctrl_t ctrl;
	logic [1:0]  x_target;
	logic [MEM_ADDR_W-1:0] x_addr;
	logic        x_write;

	logic [2:0]  bank_select_d;
	logic        prg_swap_d;
	logic        chr_invert_d;
	bank_regs_t  bank_regs_d;
	logic        mirror_d;
	logic [7:0]  irq_period_d;
	logic [7:0]  irq_count_d;
	logic        irq_rearm_d;
	logic        irq_en_d;
	logic        irq_pend_d;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign ctrl = '{
		prg_size_log2: prg_size_q,
		chr_size_log2: chr_size_q,
		chr_is_ram:    chr_ram_q,
		prg_swap:      prg_swap_q,
		chr_invert:    chr_invert_q
	};

	bmsi_xlate u_xlate (
		.req_type  (req_s1),
		.addr      (addr_s1),
		.ctrl      (ctrl),
		.bank_regs (bank_regs_q),
		.target    (x_target),
		.mem_addr  (x_addr),
		.mem_write (x_write)
	);

	always_comb begin
		bank_select_d = bank_select_q;
		prg_swap_d = prg_swap_q;
		chr_invert_d = chr_invert_q;
		bank_regs_d = bank_regs_q;
		mirror_d = mirror_q;
		irq_period_d = irq_period_q;
		irq_count_d = irq_count_q;
		irq_rearm_d = irq_rearm_q;
		irq_en_d = irq_en_q;
		irq_pend_d = irq_pend_q;
		if (req_s1 == REQ_CPU_WR && addr_s1[15]) begin
			unique case (addr_s1[14:13])
				REG_BANK: begin
					if (!addr_s1[0]) begin
						bank_select_d = data_s1[2:0];
						prg_swap_d = data_s1[6];
						chr_invert_d = data_s1[7];
					end else begin
						bank_regs_d[bank_select_q] = data_s1;
					end
				end
				REG_MIRROR: begin
					if (!addr_s1[0]) begin
						mirror_d = data_s1[0];
					end
				end
				REG_IRQ_CNT: begin
					if (!addr_s1[0]) begin
						irq_period_d = data_s1;
					end else begin
						irq_count_d = '0;
						irq_rearm_d = 1'b1;
					end
				end
				REG_IRQ_EN: begin
					if (!addr_s1[0]) begin
						irq_en_d = 1'b0;
						irq_pend_d = 1'b0;
					end else begin
						irq_en_d = 1'b1;
					end
				end
				default: begin
					mirror_d = mirror_q;
				end
			endcase
		end else if (req_s1 == REQ_TICK) begin
			if (irq_count_q == '0 || irq_rearm_q) begin
				irq_count_d = irq_period_q;
				irq_rearm_d = 1'b0;
			end else begin
				irq_count_d = irq_count_q - 8'd1;
			end
			if (irq_count_d == '0 && irq_en_q) begin
				irq_pend_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_size_q <= '0;
			chr_size_q <= '0;
			chr_ram_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PRG_SIZE: prg_size_q <= cfg_data;
				CFG_CHR_SIZE: chr_size_q <= cfg_data;
				CFG_CHR_RAM: chr_ram_q <= cfg_data[0];
				default: chr_ram_q <= chr_ram_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			prg_swap_q <= 1'b0;
			chr_invert_q <= 1'b0;
			bank_regs_q <= '0;
			mirror_q <= 1'b0;
			irq_period_q <= '0;
			irq_count_q <= '0;
			irq_rearm_q <= 1'b0;
			irq_en_q <= 1'b0;
			irq_pend_q <= 1'b0;
		end else if (advance) begin
			bank_select_q <= bank_select_d;
			prg_swap_q <= prg_swap_d;
			chr_invert_q <= chr_invert_d;
			bank_regs_q <= bank_regs_d;
			mirror_q <= mirror_d;
			irq_period_q <= irq_period_d;
			irq_count_q <= irq_count_d;
			irq_rearm_q <= irq_rearm_d;
			irq_en_q <= irq_en_d;
			irq_pend_q <= irq_pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_type;
			addr_s1 <= addr;
			data_s1 <= data;
		end
		if (advance) begin
			target_q <= x_target;
			mem_addr_q <= x_addr;
			mem_write_q <= x_write;
			irq_q <= irq_pend_d;
			mirror_out_q <= mirror_d;
		end
	end

	assign out_valid = out_valid_q;
	assign target = target_q;
	assign mem_addr = mem_addr_q;
	assign mem_write = mem_write_q;
	assign irq_line = irq_q;
	assign mirror_horizontal = mirror_out_q;

endmodule

// File: sv/bmsi_checker.sv
// Port-level checks for the bank mapper core, attached by the bind at the end.
// Depends on bmsi_pkg and the top level's port list.
module bmsi_checker import bmsi_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            target,
	input logic [MEM_ADDR_W-1:0] mem_addr,
	input logic                  mem_write,
	input logic                  irq_line,
	input logic                  mirror_horizontal
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target) && $stable(mem_addr)
			&& $stable(mem_write) && $stable(irq_line) && $stable(mirror_horizontal))
		else $error("result word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	a_none_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_NONE |-> mem_addr == '0 && !mem_write)
		else $error("no-target word carries an address or write");

	a_ram_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_PRG_RAM |-> mem_addr[MEM_ADDR_W-1:13] == '0)
		else $error("PRG RAM address out of range");

	a_chr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_CHR |-> mem_addr[MEM_ADDR_W-1:CHR_ADDR_BITS] == '0)
		else $error("CHR address out of range");

endmodule

bind bank_mapper_scanline_irq_core bmsi_checker u_bmsi_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for bank_mapper_scanline_irq_core: bus words go through a
// valid/ready channel, a local model of the mapper predicts each translated word.
// Depends on bmsi_pkg and the RTL of the block; reads no files.
module testbench;
	import bmsi_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [1:0]            tgt;
		logic [MEM_ADDR_W-1:0] maddr;
		logic                  wr;
		logic                  irq;
		logic                  mirror;
	} xlat_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_idx = '0;
	logic [2:0]            cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [2:0]            req_type = '0;
	logic [15:0]           addr = '0;
	logic [7:0]            data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            target;
	logic [MEM_ADDR_W-1:0] mem_addr;
	logic                  mem_write;
	logic                  irq_line;
	logic                  mirror_horizontal;

	// Local copy of the mapper state and size settings.
	logic [2:0] prg_lg = '0;
	logic [2:0] chr_lg = '0;
	logic       chr_ram = 1'b1;
	logic [2:0] bank_sel = '0;
	logic       prg_swap = 1'b0;
	logic       chr_inv = 1'b0;
	logic [7:0] bank_regs [8] = '{default: 8'h00};
	logic       mirror_h = 1'b0;
	logic [7:0] irq_period = '0;
	logic [7:0] irq_cnt = '0;
	logic       irq_rearm = 1'b0;
	logic       irq_en = 1'b0;
	logic       irq_pend = 1'b0;

	xlat_word_t translations_due [$];
	int err_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int size_settings = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	bank_mapper_scanline_irq_core DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [MEM_ADDR_W-1:0] prg_rom_address(logic [15:0] a);
		int n, mask, bank;
		n = ((prg_lg > SIZE_LOG2_MAX) ? 5 : int'(prg_lg)) + 14;
		if (n > PRG_ADDR_BITS) begin
			n = PRG_ADDR_BITS;
		end
		mask = (1 << (n - 13)) - 1;
		case (a[14:13])
			2'd1: bank = int'(bank_regs[7]);
			2'd3: bank = mask;
			default: bank = ((a[14:13] == 2'd0) != prg_swap) ? int'(bank_regs[6])
				: ((mask - 1) & mask);
		endcase
		return MEM_ADDR_W'(((bank & mask) << 13) | int'(a[12:0]));
	endfunction

	function automatic logic [MEM_ADDR_W-1:0] chr_address(logic [15:0] a);
		int n, mask, bank;
		logic [2:0] slot;
		n = ((chr_lg > SIZE_LOG2_MAX) ? 5 : int'(chr_lg)) + 13;
		if (n > CHR_ADDR_BITS) begin
			n = CHR_ADDR_BITS;
		end
		mask = (1 << (n - 10)) - 1;
		slot = a[12:10] ^ {chr_inv, 2'b00};
		if (slot < 3'd4) begin
			bank = int'({bank_regs[slot >> 1][7:1], slot[0]});
		end else begin
			bank = int'(bank_regs[slot - 3'd2]);
		end
		return MEM_ADDR_W'(((bank & mask) << 10) | int'(a[9:0]));
	endfunction

	function automatic void program_register(logic [15:0] a, logic [7:0] d);
		case (a[14:13])
			REG_BANK: begin
				if (!a[0]) begin
					bank_sel = d[2:0];
					prg_swap = d[6];
					chr_inv = d[7];
				end else begin
					bank_regs[bank_sel] = d;
				end
			end
			REG_MIRROR: begin
				if (!a[0]) begin
					mirror_h = d[0];
				end
			end
			REG_IRQ_CNT: begin
				if (!a[0]) begin
					irq_period = d;
				end else begin
					irq_cnt = '0;
					irq_rearm = 1'b1;
				end
			end
			default: begin
				if (!a[0]) begin
					irq_en = 1'b0;
					irq_pend = 1'b0;
				end else begin
					irq_en = 1'b1;
				end
			end
		endcase
	endfunction

	function automatic xlat_word_t map_access(logic [2:0] req, logic [15:0] a, logic [7:0] d);
		xlat_word_t r;
		r = '0;
		case (req)
			REQ_CPU_WR, REQ_CPU_RD: begin
				if (a >= 16'h8000) begin
					if (req == REQ_CPU_WR) begin
						program_register(a, d);
					end else begin
						r.tgt = TGT_PRG_ROM;
						r.maddr = prg_rom_address(a);
					end
				end else if (a >= 16'h6000) begin
					r.tgt = TGT_PRG_RAM;
					r.maddr = MEM_ADDR_W'(a[12:0]);
					r.wr = (req == REQ_CPU_WR);
				end
			end
			REQ_PPU_RD: begin
				if (a <= 16'h1FFF) begin
					r.tgt = TGT_CHR;
					r.maddr = chr_address(a);
				end
			end
			REQ_PPU_WR: begin
				if (a <= 16'h1FFF && chr_ram) begin
					r.tgt = TGT_CHR;
					r.maddr = chr_address(a);
					r.wr = 1'b1;
				end
			end
			REQ_TICK: begin
				if (irq_cnt == 8'd0 || irq_rearm) begin
					irq_cnt = irq_period;
					irq_rearm = 1'b0;
				end else begin
					irq_cnt = irq_cnt - 8'd1;
				end
				if (irq_cnt == 8'd0 && irq_en) begin
					irq_pend = 1'b1;
				end
			end
			default: ;
		endcase
		r.irq = irq_pend;
		r.mirror = mirror_h;
		return r;
	endfunction

	task automatic check_field(string field, logic [MEM_ADDR_W-1:0] want,
		logic [MEM_ADDR_W-1:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		xlat_word_t due;
		if (out_valid && out_ready) begin
			if (translations_due.size() == 0) begin
				err_count++;
				$display("%0t ns: unexpected word, expected none, actual target %0h addr %0h",
					$time, target, mem_addr);
			end else begin
				due = translations_due.pop_front();
				words_checked++;
				check_field("target", MEM_ADDR_W'(due.tgt), MEM_ADDR_W'(target));
				check_field("mem_addr", due.maddr, mem_addr);
				check_field("mem_write", MEM_ADDR_W'(due.wr), MEM_ADDR_W'(mem_write));
				check_field("irq_line", MEM_ADDR_W'(due.irq), MEM_ADDR_W'(irq_line));
				check_field("mirror_horizontal", MEM_ADDR_W'(due.mirror),
					MEM_ADDR_W'(mirror_horizontal));
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	task automatic set_idling(int in_pct, int out_pct);
		in_idle_pct = in_pct;
		out_stall_pct = out_pct;
	endtask

	task automatic send_word(logic [2:0] req, logic [15:0] a, logic [7:0] d);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		addr <= a;
		data <= d;
		do @(posedge clk); while (!in_ready);
		translations_due.push_back(map_access(req, a, d));
		words_sent++;
	endtask

	task automatic program_mapper(logic [1:0] region, logic odd, logic [7:0] d);
		send_word(REQ_CPU_WR, {1'b1, region, 12'($urandom), odd}, d);
	endtask

	task automatic wait_for_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (translations_due.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		if (translations_due.size() != 0) begin
			err_count++;
			$display("%0t ns: %0d expected words never arrived", $time, translations_due.size());
			translations_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [2:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PRG_SIZE: prg_lg = val;
			CFG_CHR_SIZE: chr_lg = val;
			CFG_CHR_RAM: chr_ram = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_sizes(logic [2:0] prg, logic [2:0] chr, logic [2:0] ram);
		wait_for_results();
		write_cfg(CFG_PRG_SIZE, prg);
		write_cfg(CFG_CHR_SIZE, chr);
		write_cfg(CFG_CHR_RAM, ram);
		size_settings++;
	endtask

	task automatic send_random_word();
		int pick;
		logic [15:0] a;
		logic [7:0] d;
		pick = $urandom_range(99);
		a = 16'($urandom);
		d = 8'($urandom);
		if (pick < 25) begin
			if ($urandom_range(1) == 0) begin
				d = 8'($urandom_range(0, 6));
			end
			program_mapper(2'($urandom), 1'($urandom), d);
		end else if (pick < 45) begin
			send_word(REQ_CPU_RD, a | 16'h8000, d);
		end else if (pick < 55) begin
			send_word($urandom_range(1) ? REQ_CPU_RD : REQ_CPU_WR, {3'b011, a[12:0]}, d);
		end else if (pick < 60) begin
			send_word($urandom_range(1) ? REQ_CPU_RD : REQ_CPU_WR, a, d);
		end else if (pick < 80) begin
			send_word($urandom_range(1) ? REQ_PPU_RD : REQ_PPU_WR, {3'b000, a[12:0]}, d);
		end else if (pick < 85) begin
			send_word($urandom_range(1) ? REQ_PPU_RD : REQ_PPU_WR, a, d);
		end else if (pick < 97) begin
			send_word(REQ_TICK, a, d);
		end else begin
			send_word(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), a, d);
		end
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		send_word(REQ_CPU_RD, 16'h0000, 8'h00);
		send_word(REQ_CPU_WR, 16'h5FFF, 8'hFF);
		send_word(REQ_CPU_WR, 16'h6000, 8'hFF);
		send_word(REQ_CPU_RD, 16'h7FFF, 8'h00);
		send_word(REQ_CPU_RD, 16'hFFFF, 8'h00);
		program_mapper(REG_BANK, 1'b0, 8'hC7);
		program_mapper(REG_BANK, 1'b1, 8'hFF);
		program_mapper(REG_BANK, 1'b0, 8'hC6);
		program_mapper(REG_BANK, 1'b1, 8'hAA);
		send_word(REQ_CPU_RD, 16'h8000, 8'h00);
		send_word(REQ_CPU_RD, 16'hA000, 8'h00);
		send_word(REQ_CPU_RD, 16'hC000, 8'h00);
		program_mapper(REG_MIRROR, 1'b0, 8'hFF);
		program_mapper(REG_MIRROR, 1'b1, 8'h00);
		send_word(REQ_PPU_RD, 16'h0000, 8'h00);
		send_word(REQ_PPU_RD, 16'h1FFF, 8'h00);
		send_word(REQ_PPU_WR, 16'h0C00, 8'h55);
		send_word(REQ_PPU_RD, 16'h2000, 8'h00);
		send_word(REQ_PPU_WR, 16'hFFFF, 8'hFF);
		program_mapper(REG_IRQ_CNT, 1'b0, 8'h01);
		program_mapper(REG_IRQ_CNT, 1'b1, 8'h00);
		program_mapper(REG_IRQ_EN, 1'b1, 8'h00);
		send_word(REQ_TICK, 16'h0000, 8'h00);
		send_word(REQ_TICK, 16'hFFFF, 8'hFF);
		program_mapper(REG_IRQ_EN, 1'b0, 8'h00);
		send_word(REQ_SPARE_FIRST, 16'h8001, 8'h07);
		send_word(REQ_SPARE_LAST, 16'h0400, 8'hFF);
		wait_for_results();
	endtask

	task automatic test_size_settings();
		logic [2:0] prg_pick [6] = '{3'd0, 3'd5, 3'd7, 3'd6, 3'd1, 3'd2};
		logic [2:0] chr_pick [6] = '{3'd0, 3'd5, 3'd6, 3'd7, 3'd3, 3'd4};
		logic [2:0] ram_pick [6] = '{3'd1, 3'd0, 3'd1, 3'd6, 3'd3, 3'd0};
		for (int i = 0; i < 6; i++) begin
			set_sizes(prg_pick[i], chr_pick[i], ram_pick[i]);
			case (i % 4)
				0: set_idling(0, 0);
				1: set_idling(53, 0);
				2: set_idling(0, 53);
				default: set_idling(20, 20);
			endcase
			repeat (50) send_random_word();
		end
		wait_for_results();
		write_cfg(CFG_SPARE, 3'($urandom));
		repeat (10) send_random_word();
		wait_for_results();
	endtask

	task automatic test_scanline_irq();
		set_idling(20, 20);
		repeat (40) begin
			program_mapper(REG_IRQ_CNT, 1'b0, 8'($urandom_range(0, 5)));
			program_mapper(REG_IRQ_CNT, 1'b1, 8'($urandom));
			program_mapper(REG_IRQ_EN, $urandom_range(3) != 0, 8'($urandom));
			repeat ($urandom_range(1, 8)) begin
				send_word(REQ_TICK, 16'($urandom), 8'($urandom));
				if ($urandom_range(3) == 0) begin
					send_word(REQ_PPU_RD, {3'b000, 13'($urandom)}, 8'($urandom));
				end
			end
			if ($urandom_range(1) == 0) begin
				program_mapper(REG_IRQ_EN, 1'b0, 8'($urandom));
			end
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			set_sizes(3'($urandom), 3'($urandom), 3'($urandom));
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(53, 0);
				2: set_idling(0, 53);
				default: set_idling(20, 20);
			endcase
			repeat (135) send_random_word();
			// Hold the bus until the pipeline has emptied, then resume.
			wait_for_results();
			repeat (135) send_random_word();
		end
		wait_for_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_settings();
		test_scanline_irq();
		test_random_traffic();
		wait_for_results();
		$display("Sent %0d bus words and checked %0d translations over %0d size settings,",
			words_sent, words_checked, size_settings);
		$display("with scanline IRQ sequences and four sender and receiver idling mixes.");
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
sv/bmsi_pkg.sv
sv/bmsi_xlate.sv
sv/bank_mapper_scanline_irq_core.sv
sv/bmsi_checker.sv
sim/testbench.sv
